@@ rtl/jia_pkg.sv @@
package jia_pkg;

   localparam int DATA_W    = 64;
   localparam int HALF_W    = 32;
   localparam int DIV_STEPS = 64;

   typedef enum logic [4:0] {
      ACT_ADD  = 5'd0,
      ACT_SUB  = 5'd1,
      ACT_MUL  = 5'd2,
      ACT_AND  = 5'd3,
      ACT_OR   = 5'd4,
      ACT_XOR  = 5'd5,
      ACT_SHL  = 5'd6,
      ACT_SHR  = 5'd7,
      ACT_USHR = 5'd8,
      ACT_DIV  = 5'd9,
      ACT_REM  = 5'd10,
      ACT_CMP  = 5'd11,
      ACT_EQ   = 5'd12,
      ACT_NE   = 5'd13,
      ACT_LT   = 5'd14,
      ACT_LE   = 5'd15,
      ACT_GT   = 5'd16,
      ACT_GE   = 5'd17
   } action_type;

   // control and early result riding along the divider stages
   typedef struct packed {
      logic              valid;
      action_type        act;
      logic              is_long;
      logic              ok;
      logic              neg_q;
      logic              neg_r;
      logic [DATA_W-1:0] value;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              folded;
   } result_type;

   function automatic logic [DATA_W-1:0] sext32(input logic [DATA_W-1:0] x);
      sext32 = {{HALF_W{x[HALF_W-1]}}, x[HALF_W-1:0]};
   endfunction

endpackage

@@ rtl/jia_front.sv @@
module jia_front
   import jia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_valid,
   input  action_type        in_act,
   input  logic              in_long,
   input  logic [DATA_W-1:0] in_a,
   input  logic [DATA_W-1:0] in_b,
   output side_type          side_out,
   output logic [DATA_W-1:0] mag_a_out,
   output logic [DATA_W-1:0] mag_b_out
);

   // first stage: raw operands
   logic              v1_ff;
   action_type        act1_ff;
   logic              long1_ff;
   logic [DATA_W-1:0] a1_ff, b1_ff;

   // second stage: simple results, multiply partial products, magnitudes
   logic              v2_ff;
   action_type        act2_ff;
   logic              long2_ff, ok2_ff, negq2_ff, negr2_ff;
   logic [DATA_W-1:0] simple2_ff, pp0_ff, maga2_ff, magb2_ff;
   logic [HALF_W-1:0] pp1_ff, pp2_ff;

   logic [DATA_W-1:0] a_x, b_x, ushr_src, simple_in, maga_in, magb_in;
   logic [DATA_W-1:0] pp0_in, pp1_full, pp2_full;
   logic [5:0]        shamt;
   logic              lt, gt, ok_in, b_zero;
   logic [HALF_W-1:0] prod_hi;

   always_comb begin
      a_x      = long1_ff ? a1_ff : sext32(a1_ff);
      b_x      = long1_ff ? b1_ff : sext32(b1_ff);
      shamt    = long1_ff ? b_x[5:0] : {1'b0, b_x[4:0]};
      ushr_src = long1_ff ? a_x : {{HALF_W{1'b0}}, a_x[HALF_W-1:0]};
      lt       = $signed(a_x) < $signed(b_x);
      gt       = $signed(b_x) < $signed(a_x);
      b_zero   = (b_x == '0);
      maga_in  = a_x[DATA_W-1] ? (~a_x + 1'b1) : a_x;
      magb_in  = b_x[DATA_W-1] ? (~b_x + 1'b1) : b_x;
      pp0_in   = a_x[HALF_W-1:0] * b_x[HALF_W-1:0];
      pp1_full = a_x[HALF_W-1:0] * b_x[DATA_W-1:HALF_W];
      pp2_full = a_x[DATA_W-1:HALF_W] * b_x[HALF_W-1:0];
      simple_in = '0;
      ok_in     = 1'b1;
      case (act1_ff)
         ACT_ADD:  simple_in = a_x + b_x;
         ACT_SUB:  simple_in = a_x - b_x;
         ACT_MUL:  simple_in = '0;
         ACT_AND:  simple_in = a_x & b_x;
         ACT_OR:   simple_in = a_x | b_x;
         ACT_XOR:  simple_in = a_x ^ b_x;
         ACT_SHL:  simple_in = a_x << shamt;
         ACT_SHR:  simple_in = $unsigned($signed(a_x) >>> shamt);
         ACT_USHR: simple_in = ushr_src >> shamt;
         ACT_DIV,
         ACT_REM:  ok_in = !b_zero;
         ACT_CMP:  simple_in = gt ? DATA_W'(1) : (lt ? '1 : '0);
         ACT_EQ:   simple_in = DATA_W'(a_x == b_x);
         ACT_NE:   simple_in = DATA_W'(a_x != b_x);
         ACT_LT:   simple_in = DATA_W'(lt);
         ACT_LE:   simple_in = DATA_W'(!gt);
         ACT_GT:   simple_in = DATA_W'(gt);
         ACT_GE:   simple_in = DATA_W'(!lt);
         default:  ok_in = 1'b0;
      endcase
      // relational tests exist only for int
      if (long1_ff && (act1_ff == ACT_EQ || act1_ff == ACT_NE || act1_ff == ACT_LT ||
                       act1_ff == ACT_LE || act1_ff == ACT_GT || act1_ff == ACT_GE))
         ok_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         act1_ff    <= in_act;
         long1_ff   <= in_long;
         a1_ff      <= in_a;
         b1_ff      <= in_b;
         act2_ff    <= act1_ff;
         long2_ff   <= long1_ff;
         ok2_ff     <= ok_in;
         negq2_ff   <= a_x[DATA_W-1] ^ b_x[DATA_W-1];
         negr2_ff   <= a_x[DATA_W-1];
         simple2_ff <= simple_in;
         pp0_ff     <= pp0_in;
         pp1_ff     <= pp1_full[HALF_W-1:0];
         pp2_ff     <= pp2_full[HALF_W-1:0];
         maga2_ff   <= maga_in;
         magb2_ff   <= magb_in;
      end
   end

   always_comb begin
      prod_hi = pp1_ff + pp2_ff;
      side_out.valid   = v2_ff;
      side_out.act     = act2_ff;
      side_out.is_long = long2_ff;
      side_out.ok      = ok2_ff;
      side_out.neg_q   = negq2_ff;
      side_out.neg_r   = negr2_ff;
      side_out.value   = (act2_ff == ACT_MUL) ? (pp0_ff + {prod_hi, {HALF_W{1'b0}}})
                                              : simple2_ff;
   end

   assign mag_a_out = maga2_ff;
   assign mag_b_out = magb2_ff;

endmodule

@@ rtl/jia_div.sv @@
module jia_div
   import jia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  side_type          side_in,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output side_type          side_out,
   output logic [DATA_W-1:0] quo_out,
   output logic [DATA_W-1:0] rem_out
);

   side_type          side_ff [DIV_STEPS+1];
   logic [DATA_W-1:0] rem_ff  [DIV_STEPS+1];
   logic [DATA_W-1:0] quo_ff  [DIV_STEPS+1];
   logic [DATA_W-1:0] dvs_ff  [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else if (ce) begin
         side_ff[0].valid <= side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[0].act     <= side_in.act;
         side_ff[0].is_long <= side_in.is_long;
         side_ff[0].ok      <= side_in.ok;
         side_ff[0].neg_q   <= side_in.neg_q;
         side_ff[0].neg_r   <= side_in.neg_r;
         side_ff[0].value   <= side_in.value;
         rem_ff[0]          <= '0;
         quo_ff[0]          <= dividend;
         dvs_ff[0]          <= divisor;
      end
   end

   // one restoring step per stage, quotient bits shift in from the bottom
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DATA_W:0]   shifted, diff;
      logic              take;
      logic [DATA_W-1:0] rem_in, quo_in;

      always_comb begin
         shifted = {rem_ff[k], quo_ff[k][DATA_W-1]};
         diff    = shifted - {1'b0, dvs_ff[k]};
         take    = !diff[DATA_W];
         rem_in  = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in  = {quo_ff[k][DATA_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k+1].valid <= 1'b0;
         end else if (ce) begin
            side_ff[k+1].valid <= side_ff[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            side_ff[k+1].act     <= side_ff[k].act;
            side_ff[k+1].is_long <= side_ff[k].is_long;
            side_ff[k+1].ok      <= side_ff[k].ok;
            side_ff[k+1].neg_q   <= side_ff[k].neg_q;
            side_ff[k+1].neg_r   <= side_ff[k].neg_r;
            side_ff[k+1].value   <= side_ff[k].value;
            rem_ff[k+1]          <= rem_in;
            quo_ff[k+1]          <= quo_in;
            dvs_ff[k+1]          <= dvs_ff[k];
         end
      end
   end

   assign side_out = side_ff[DIV_STEPS];
   assign quo_out  = quo_ff[DIV_STEPS];
   assign rem_out  = rem_ff[DIV_STEPS];

endmodule

@@ rtl/jia_outq.sv @@
module jia_outq
   import jia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       pop;

   // pushes only arrive while the skid slot is empty
   assign room = !skid_valid_ff;
   assign pop  = head_valid_ff && out_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff || pop) begin
         head_in       = skid_valid_ff ? skid_ff : push_data;
         head_valid_in = skid_valid_ff || push;
         skid_in       = push_data;
         skid_valid_in = skid_valid_ff && push;
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

endmodule

@@ rtl/jvm_integer_alu_top.sv @@
// Java-semantics integer ALU: one binary operation (add, sub, mul, bitwise, shifts,
// truncating div/rem, three-way compare, int relational tests) on 32-bit or 64-bit
// operands per word. A new word is taken every cycle while the skid slot of the output
// buffer is empty; every word, whatever its operation, passes through the 64-stage
// radix-2 divider, so all results come out in order. A two-entry output
// buffer absorbs backpressure; req_tready drops only after rsp_tready has been low.
// rsp_tuser is 0 for division by zero, relational tests in long mode and unknown
// operations, and then rsp_tdata is 0. Int results are sign-extended.
module jvm_integer_alu_top
   import jia_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // operand_a[63:0], operand_b[127:64]
   input  logic [5:0]   req_tuser,   // action[4:0], is_long[5]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // value[63:0]
   output logic         rsp_tuser    // folded[0]
);

   logic              ce;
   side_type          front_side, div_side;
   logic [DATA_W-1:0] mag_a, mag_b, quo, rem;
   logic [DATA_W-1:0] quo_s, rem_s, sel;
   result_type        res, out_res;

   jia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_tvalid),
      .in_act    (action_type'(req_tuser[4:0])),
      .in_long   (req_tuser[5]),
      .in_a      (req_tdata[63:0]),
      .in_b      (req_tdata[127:64]),
      .side_out  (front_side),
      .mag_a_out (mag_a),
      .mag_b_out (mag_b)
   );

   jia_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .side_in  (front_side),
      .dividend (mag_a),
      .divisor  (mag_b),
      .side_out (div_side),
      .quo_out  (quo),
      .rem_out  (rem)
   );

   always_comb begin
      quo_s = div_side.neg_q ? (~quo + 1'b1) : quo;
      rem_s = div_side.neg_r ? (~rem + 1'b1) : rem;
      case (div_side.act)
         ACT_DIV: sel = quo_s;
         ACT_REM: sel = rem_s;
         default: sel = div_side.value;
      endcase
      if (!div_side.ok)
         res.value = '0;
      else if (!div_side.is_long)
         res.value = sext32(sel);
      else
         res.value = sel;
      res.folded = div_side.ok;
   end

   jia_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (ce && div_side.valid),
      .push_data (res),
      .room      (ce),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign req_tready = ce;
   assign rsp_tdata  = out_res.value;
   assign rsp_tuser  = out_res.folded;

endmodule

@@ rtl/jia_checker.sv @@
module jia_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic         rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_unfolded_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("unfolded result carries a nonzero value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

endmodule

bind jvm_integer_alu_top jia_checker u_jia_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/tb_jvm_integer_alu_top.sv @@
`timescale 1ns / 1ps

module tb_jvm_integer_alu_top;
   import jia_pkg::*;

   typedef struct {
      logic [4:0]  act;
      logic        is_long;
      logic [63:0] a;
      logic [63:0] b;
   } op_word_type;

   typedef struct {
      logic [63:0] value;
      logic        folded;
   } alu_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [5:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         req_tready_q;

   op_word_type    pending_ops[$];
   alu_result_type expected_results[$];
   int          error_count = 0;
   bit          stim_done = 0;
   bit          no_idle = 0;
   bit          hold_off = 0;

   jvm_integer_alu_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic logic [63:0] sx32(input logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

   function automatic alu_result_type java_alu_eval(input op_word_type w);
      alu_result_type r;
      logic signed [63:0] a, b;
      logic [63:0]    v;
      logic [5:0]     sh;
      logic           ok;
      a = w.is_long ? w.a : sx32(w.a);
      b = w.is_long ? w.b : sx32(w.b);
      sh = w.is_long ? b[5:0] : {1'b0, b[4:0]};
      ok = 1'b1;
      v = '0;
      case (w.act)
         ACT_ADD:  v = a + b;
         ACT_SUB:  v = a - b;
         ACT_MUL:  v = a * b;
         ACT_AND:  v = a & b;
         ACT_OR:   v = a | b;
         ACT_XOR:  v = a ^ b;
         ACT_SHL:  v = a << sh;
         ACT_SHR:  v = a >>> sh;
         ACT_USHR: v = (w.is_long ? a : {32'd0, a[31:0]}) >> sh;
         ACT_DIV, ACT_REM: begin
            if (b == 0) ok = 1'b0;
            else if (a == {1'b1, 63'd0} && b == '1) v = (w.act == ACT_DIV) ? a : 64'd0;
            else v = (w.act == ACT_DIV) ? a / b : a % b;
         end
         ACT_CMP: v = (a > b) ? 64'd1 : ((a < b) ? '1 : 64'd0);
         ACT_EQ, ACT_NE, ACT_LT, ACT_LE, ACT_GT, ACT_GE: begin
            if (w.is_long) ok = 1'b0;
            else case (w.act)
               ACT_EQ: v = 64'(a == b);
               ACT_NE: v = 64'(a != b);
               ACT_LT: v = 64'(a < b);
               ACT_LE: v = 64'(a <= b);
               ACT_GT: v = 64'(a > b);
               default: v = 64'(a >= b);
            endcase
         end
         default: ok = 1'b0;
      endcase
      if (!ok) v = '0;
      else if (!w.is_long) v = sx32(v);
      r.value = v;
      r.folded = ok;
      return r;
   endfunction

   function automatic logic [63:0] pick_operand(input bit lng);
      logic [63:0] x;
      x = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: x = lng ? {1'b1, 63'd0} : {$urandom, 32'h8000_0000};
         1: x = lng ? {1'b0, {63{1'b1}}} : {$urandom, 32'h7fff_ffff};
         2: x = '1;
         3: x = {$urandom, 32'd0} & (lng ? 64'd0 : '1);
         4: x = 64'($urandom_range(0, 70));
         5: x = -64'($urandom_range(1, 70));
         default: ;
      endcase
      return x;
   endfunction

   task automatic add_op(input logic [4:0] act, input logic lng,
                         input logic [63:0] a, input logic [63:0] b);
      op_word_type w;
      w.act = act; w.is_long = lng; w.a = a; w.b = b;
      pending_ops.push_back(w);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready_q) begin
         if (pending_ops.size() > 0 && (no_idle || $urandom_range(0, 99) >= 34)) begin
            op_word_type w;
            w = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {w.b, w.a};
            req_tuser <= {w.is_long, w.act};
            expected_results.push_back(java_alu_eval(w));
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // latch acceptance at the rising edge; the driver acts on it at the next falling edge
   always @(posedge clock) req_tready_q <= req_tvalid & req_tready;

   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle || ($urandom_range(0, 99) >= 34);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected word value=%h folded=%b", $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            alu_result_type e;
            e = expected_results.pop_front();
            if (e.value !== rsp_tdata) begin
               $display("%0t: value expected %h actual %h", $time, e.value, rsp_tdata);
               error_count++;
            end
            if (e.folded !== rsp_tuser) begin
               $display("%0t: folded expected %b actual %b", $time, e.folded, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("tb_jvm_integer_alu_top: done, errors");
      $finish;
   end

   initial begin
      logic [4:0] act;
      bit lng;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every operation in a randomly chosen width, then the corner cases
      for (int i = 0; i <= 17; i++)
         add_op(5'(i), 1'($urandom_range(0, 1)), {$urandom, $urandom}, 64'($urandom_range(1, 99)));
      add_op(ACT_DIV, 1'b1, {1'b1, 63'd0}, '1);
      add_op(ACT_REM, 1'b1, {1'b1, 63'd0}, '1);
      add_op(ACT_DIV, 1'b0, 64'h1234_5678_8000_0000, 64'h0000_0001_ffff_ffff);
      add_op(ACT_REM, 1'b0, 64'h0000_0000_8000_0000, '1);
      add_op(ACT_DIV, 1'b0, '1, 64'hffff_ffff_0000_0000);
      add_op(ACT_REM, 1'b1, 64'd7, 64'd0);
      add_op(ACT_LT, 1'b1, 64'd1, 64'd2);
      add_op(5'd31, 1'b0, '1, '1);
      add_op(5'd18, 1'b1, '1, '1);

      for (int i = 0; i < 1250; i++) begin
         lng = 1'($urandom_range(0, 1));
         act = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                            : 5'($urandom_range(0, 17));
         add_op(act, lng, pick_operand(lng), pick_operand(lng));
         if (i == 300) no_idle = 1'b1;
         if (i == 500) no_idle = 1'b0;
      end

      // long receiver stall while words keep arriving
      wait (pending_ops.size() < 900);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      @(negedge clock);
      hold_off = 1'b0;

      // no-idle stretch toward the end
      wait (pending_ops.size() < 400);
      no_idle = 1'b1;
      wait (pending_ops.size() < 150);
      no_idle = 1'b0;

      wait (pending_ops.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_jvm_integer_alu_top: done, clean");
      end else begin
         $display("tb_jvm_integer_alu_top: done, errors");
      end
      $finish;
   end

endmodule
